>>> src/lnx_pkg.sv
// Shared types and constants for the LCD nibble expander sequencer.
package lnx_pkg;

  typedef enum logic [1:0] {
    CMD_INSTR  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_CURSOR = 2'd2,
    CMD_NIBBLE = 2'd3
  } cmd_e_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] value;
    logic [1:0] row;
    logic [5:0] column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic       last;
  } out_item_t;

  // One classified request: the byte to send, RS, and whether only its high nibble goes out.
  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       single;
  } job_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic head_valid;
    logic full;
  } q_status_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;

  localparam logic [7:0] BIT_RS      = 8'h01;
  localparam logic [7:0] BIT_E       = 8'h04;
  localparam logic [7:0] BIT_BL      = 8'h08;
  localparam logic [7:0] CMD_DDRAM   = 8'h80;
  localparam logic [7:0] ROW1_ADDR   = 8'h40;
  localparam logic [7:0] NIBBLE_MASK = 8'hF0;

  localparam logic REG_DISPLAY_READY = 1'b0;
  localparam logic REG_BACKLIGHT_ON  = 1'b1;

endpackage

>>> src/lnx_front.sv
// Front end: accepts requests and turns each into a byte job for the queue.
module lnx_front #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16
) (
  input  logic              in_valid,
  input  lnx_pkg::in_item_t in_item,
  input  logic              display_ready,
  input  lnx_pkg::q_status_t q_status,
  output logic              in_stall,
  output logic              push,
  output lnx_pkg::job_t     job
);
  import lnx_pkg::*;

  localparam logic [1:0] ROW_MAX = 2'(ROWS - 1);
  localparam logic [5:0] COL_MAX = 6'(COLUMNS - 1);

  logic [1:0] row_c;
  logic [5:0] col_c;
  logic [7:0] row_addr;
  logic [7:0] cursor_byte;

  always_comb begin
    row_c = (in_item.row > ROW_MAX) ? ROW_MAX : in_item.row;
    col_c = (in_item.column > COL_MAX) ? COL_MAX : in_item.column;
    row_addr = (row_c != 2'd0) ? ROW1_ADDR : 8'h00;
    cursor_byte = CMD_DDRAM | 8'(row_addr + {2'b00, col_c});
  end

  always_comb begin
    job = '0;
    unique case (cmd_e_t'(in_item.command))
      CMD_INSTR: begin
        job.data = in_item.value;
      end
      CMD_DATA: begin
        job.data = in_item.value;
        job.rs   = 1'b1;
      end
      CMD_CURSOR: begin
        job.data = cursor_byte;
      end
      CMD_NIBBLE: begin
        job.data   = in_item.value & NIBBLE_MASK;
        job.single = 1'b1;
      end
      default: begin
        job = '0;
      end
    endcase
  end

  // Hold off while the queue is full; drop requests while the display is not ready.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full && display_ready;

endmodule

>>> src/lnx_queue.sv
// Two-entry job queue between the front end and the byte sequencer.
module lnx_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lnx_pkg::job_t      push_job,
  input  logic               pop,
  output lnx_pkg::job_t      head,
  output lnx_pkg::q_status_t status
);
  import lnx_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  assign head              = mem[rd_ptr];
  assign status.head_valid = (count != '0);
  assign status.full       = (count == (QPTR_W+1)'(QDEPTH));

endmodule

>>> src/lnx_back.sv
// Back end: steps a job through its expander bytes into the output register.
module lnx_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                backlight_on,
  input  lnx_pkg::job_t       head,
  input  lnx_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lnx_pkg::out_item_t  out_item
);
  import lnx_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] step;

  job_t       src;
  logic       active;
  logic       adv;
  logic       final_step;
  logic [3:0] nib;
  logic [7:0] byte_c;

  always_comb begin
    src        = busy ? cur : head;
    active     = busy || q_status.head_valid;
    adv        = !out_valid || !out_stall;
    final_step = src.single ? (step == 2'd1) : (step == 2'd3);
    nib        = step[1] ? src.data[3:0] : src.data[7:4];
    byte_c     = {nib, 4'h0} | (backlight_on ? BIT_BL : 8'h00)
               | (step[0] ? 8'h00 : BIT_E) | (src.rs ? BIT_RS : 8'h00);
    pop        = adv && !busy && q_status.head_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= active;
      if (active) begin
        if (final_step) begin
          busy <= 1'b0;
          step <= 2'd0;
        end else begin
          busy <= 1'b1;
          step <= step + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (adv && active) begin
      out_item.expander_byte <= byte_c;
      out_item.last          <= final_step;
    end
  end

endmodule

>>> src/lcd_nibble_expander_sequencer.sv
// Top level of the LCD nibble expander sequencer: config port, front, queue and back.
// An accepted request is first written into the job queue; its first expander byte is then registered into the output.
// Throughput: one expander byte per cycle while out_stall is low, set by the back-end step counter;
//   four expander bytes per byte request, two per init nibble, none while the display is not ready.
// Input is taken back to back until the two-entry job queue fills.
// Reset (rst, synchronous, active high): queue and sequencer empty, display_ready = 0,
//   backlight_on = 1.
module lcd_nibble_expander_sequencer #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lnx_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lnx_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lnx_pkg::*;

  // Configuration registers: display_ready at 0x0, backlight_on at 0x4.
  logic display_ready;
  logic backlight_on;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_ready <= 1'b0;
      backlight_on  <= 1'b1;
    end else if (cfg_write) begin
      // Keep only bit 0 of the written data.
      if (paddr[2] == REG_DISPLAY_READY) display_ready <= pwdata[0];
      if (paddr[2] == REG_BACKLIGHT_ON)  backlight_on  <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'h0;
    if (paddr[2] == REG_DISPLAY_READY) prdata[0] = display_ready;
    else prdata[0] = backlight_on;
  end

  // Front end classifies each transaction into a job and pushes it into the queue while the display is ready.
  job_t      push_job;
  job_t      head;
  logic      push;
  logic      pop;
  q_status_t q_status;

  lnx_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .in_valid      (in_valid),
    .in_item       (in_item),
    .display_ready (display_ready),
    .q_status      (q_status),
    .in_stall      (in_stall),
    .push          (push),
    .job           (push_job)
  );

  // Short queue decouples request intake from the byte stream.
  lnx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back end walks each job: high nibble E set, E clear, then low nibble the same way; single jobs skip the low.
  lnx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .backlight_on (backlight_on),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

  // The closing byte of a request always has E clear.
  a_last_e_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last |-> !out_item.expander_byte[2])
    else $error("last byte carries E set");

  // A byte that is not the last of its request is followed at once by the next one.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_item.last |=> out_valid)
    else $error("gap inside a request byte stream");

  // An E-high byte is followed by the same nibble with E low.
  a_e_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_item.expander_byte[2] |=>
      !out_item.expander_byte[2] &&
      (out_item.expander_byte[7:4] == $past(out_item.expander_byte[7:4])))
    else $error("E strobe pair broken");

  // Nothing enters the queue when it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push)
    else $error("push into full queue");

endmodule

>>> sim/tb_lcd_nibble_expander_sequencer.sv
// Self-checking testbench for the LCD nibble expander sequencer.
`timescale 1ns / 1ps

module tb_lcd_nibble_expander_sequencer;
  import lnx_pkg::*;

  localparam int ROWS           = 2;
  localparam int COLUMNS        = 16;
  localparam int SETTLE_CYCLES  = 8;     // well past the request latency
  localparam int LONG_HOLD      = 200;   // receiver hold-off that fills the job queue
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction on any port
  localparam int DIR_ROWS       = 29;
  localparam int PHASES         = 10;

  localparam logic [2:0] ADDR_DISPLAY_READY = {REG_DISPLAY_READY, 2'b00};
  localparam logic [2:0] ADDR_BACKLIGHT_ON  = {REG_BACKLIGHT_ON, 2'b00};

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // One step of the directed sequence: a register write, or a request whose
  // bytes are either typed in (first byte in bits 31:24) or left to the predictor.
  typedef struct packed {
    logic        is_write;
    logic [2:0]  addr;
    logic [31:0] wdata;
    in_item_t    item;
    logic        typed;
    int          n;
    logic [31:0] bytes;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copies of the configuration registers, at their reset values.
  logic        shadow_ready = 1'b0;
  logic        shadow_bl    = 1'b1;

  out_item_t   lcd_bytes_due[$];
  int          mismatches = 0;
  logic        hold_req   = 1'b0;
  logic        no_gaps    = 1'b0;
  int          burst_left = 0;
  dir_row_t    directed_rows [DIR_ROWS];

  lcd_nibble_expander_sequencer #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Queue the two expander bytes of one nibble: enable high, then enable low.
  function automatic void due_nibble(input logic [7:0] nib, input logic rs, input logic fin);
    logic [7:0] base;
    out_item_t  e;
    base = (nib & NIBBLE_MASK) | (rs ? BIT_RS : 8'h00) | (shadow_bl ? BIT_BL : 8'h00);
    e.expander_byte = base | BIT_E;
    e.last = 1'b0;
    lcd_bytes_due.push_back(e);
    e.expander_byte = base & ~BIT_E;
    e.last = fin;
    lcd_bytes_due.push_back(e);
  endfunction

  // A full byte goes out high nibble first; only the low nibble closes the request.
  function automatic void due_byte(input logic [7:0] b, input logic rs);
    due_nibble(b, rs, 1'b0);
    due_nibble({b[3:0], 4'h0}, rs, 1'b1);
  endfunction

  function automatic void predict_request(input in_item_t it);
    logic [1:0] r;
    logic [5:0] c;
    logic [7:0] row_base;
    r = it.row;
    c = it.column;
    if (!shadow_ready) return;  // display absent: the request is swallowed
    case (cmd_e_t'(it.command))
      CMD_INSTR: due_byte(it.value, 1'b0);
      CMD_DATA:  due_byte(it.value, 1'b1);
      CMD_CURSOR: begin
        // Clamp to the panel, then any nonzero row lands on the second line.
        if (int'(r) >= ROWS) r = 2'(ROWS - 1);
        if (int'(c) >= COLUMNS) c = 6'(COLUMNS - 1);
        row_base = (r == 2'd0) ? 8'h00 : ROW1_ADDR;
        due_byte(CMD_DDRAM | (row_base + {2'b00, c}), 1'b0);
      end
      default: due_nibble(it.value, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic dir_row_t reg_row(input logic [2:0] addr, input logic [31:0] data);
    dir_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.addr = addr;
    r.wdata = data;
    return r;
  endfunction

  function automatic dir_row_t known_row(input cmd_e_t cmd, input logic [7:0] val,
                                         input logic [1:0] row, input logic [5:0] col,
                                         input int n, input logic [31:0] bytes);
    dir_row_t r;
    r = '0;
    r.item = '{command: cmd, value: val, row: row, column: col};
    r.typed = 1'b1;
    r.n = n;
    r.bytes = bytes;
    return r;
  endfunction

  function automatic dir_row_t checked_row(input cmd_e_t cmd, input logic [7:0] val,
                                           input logic [1:0] row, input logic [5:0] col);
    dir_row_t r;
    r = '0;
    r.item = '{command: cmd, value: val, row: row, column: col};
    return r;
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    it.command = 2'($urandom_range(0, 3));
    it.value   = 8'($urandom);
    it.row     = 2'($urandom_range(0, 3));
    // Mostly on-screen columns, with a fair share past the right edge.
    case ($urandom_range(0, 3))
      0, 1:    it.column = 6'($urandom_range(0, COLUMNS - 1));
      2:       it.column = 6'($urandom_range(COLUMNS, 63));
      default: it.column = 6'($urandom);
    endcase
    return it;
  endfunction

  // Offer one request and hold it until the transaction completes, then queue
  // what it should produce. Enter right after a rising edge.
  task automatic send_request(input in_item_t it, input logic typed, input int n,
                              input logic [31:0] bytes);
    logic      taken;
    out_item_t e;
    in_valid <= 1'b1;
    in_item  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end
    if (typed) begin
      for (int k = 0; k < n; k++) begin
        e.expander_byte = bytes[31 - 8 * k -: 8];
        e.last = (k == n - 1);
        lcd_bytes_due.push_back(e);
      end
    end else begin
      predict_request(it);
    end
  endtask

  // Bursts of random length, separated by random gaps unless no_gaps is set.
  task automatic sender_gap();
    int gap;
    gap = 0;
    if (!no_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(0, 30);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every outstanding byte, then give the block time to
  // finish any request that produced nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lcd_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = (pready === 1'b1);
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Only bit 0 of the written word is kept.
    if (addr == ADDR_DISPLAY_READY) shadow_ready = data[0];
    else if (addr == ADDR_BACKLIGHT_ON) shadow_bl = data[0];
  endtask

  // Receiver: stall on its own pattern, and honor a long hold-off on request.
  initial begin : receiver
    rx_mode_t mode;
    int       left;
    int       hold;
    int       tick;
    mode = RX_FREE;
    left = 0;
    hold = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 150);
        end
        left--;
        tick++;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
          default:  out_stall <= ((tick % 5) >= 3);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest pending expectation.
  initial begin : scoreboard
    logic      took;
    out_item_t seen;
    out_item_t want;
    forever begin
      @(negedge clk);
      took = (out_valid === 1'b1) && (out_stall === 1'b0) && !rst;
      seen = out_item;
      @(posedge clk);
      if (took) begin
        if (lcd_bytes_due.size() == 0) begin
          $error("expander byte %02h arrived with no request pending", seen.expander_byte);
          mismatches++;
        end else begin
          want = lcd_bytes_due.pop_front();
          if (seen.expander_byte !== want.expander_byte) begin
            $error("expander_byte: expected %02h, got %02h",
                   want.expander_byte, seen.expander_byte);
            mismatches++;
          end
          if (seen.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, seen.last);
            mismatches++;
          end
        end
      end
    end
  end

  // Abort when no transaction moves on any port for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (((in_valid === 1'b1) && (in_stall === 1'b0)) ||
          ((out_valid === 1'b1) && (out_stall === 1'b0)) || psel)
        idle = 0;
      else
        idle++;
    end
    $display("tb_lcd_nibble_expander_sequencer: errors");
    $finish;
  end

  initial begin : stimulus
    int       p;
    int       count;
    logic     rdy;
    logic     bl;
    in_item_t it;

    directed_rows = '{
      // Out of reset the display is not ready: everything is swallowed.
      known_row(CMD_INSTR,  8'h00, 2'd0, 6'd0,  0, 32'h0),
      known_row(CMD_DATA,   8'hFF, 2'd3, 6'd63, 0, 32'h0),
      known_row(CMD_CURSOR, 8'hFF, 2'd3, 6'd63, 0, 32'h0),
      known_row(CMD_NIBBLE, 8'h30, 2'd0, 6'd0,  0, 32'h0),
      reg_row(ADDR_DISPLAY_READY, 32'h1),
      // Ready, backlight on.
      known_row(CMD_INSTR,  8'h00, 2'd0, 6'd0,  4, 32'h0C080C08),
      known_row(CMD_INSTR,  8'hFF, 2'd3, 6'd63, 4, 32'hFCF8FCF8),
      known_row(CMD_DATA,   8'h00, 2'd0, 6'd0,  4, 32'h0D090D09),
      known_row(CMD_DATA,   8'hFF, 2'd0, 6'd0,  4, 32'hFDF9FDF9),
      known_row(CMD_NIBBLE, 8'h3F, 2'd0, 6'd0,  2, 32'h3C380000),
      known_row(CMD_NIBBLE, 8'h00, 2'd3, 6'd63, 2, 32'h0C080000),
      known_row(CMD_CURSOR, 8'h00, 2'd0, 6'd0,  4, 32'h8C880C08),
      known_row(CMD_CURSOR, 8'hFF, 2'd3, 6'd63, 4, 32'hCCC8FCF8),
      checked_row(CMD_CURSOR, 8'h00, 2'd1, 6'd15),
      checked_row(CMD_CURSOR, 8'h00, 2'd2, 6'd16),
      checked_row(CMD_CURSOR, 8'h5A, 2'd0, 6'd5),
      checked_row(CMD_INSTR,  8'hA5, 2'd2, 6'd42),
      checked_row(CMD_DATA,   8'h5A, 2'd3, 6'd63),
      checked_row(CMD_NIBBLE, 8'hFF, 2'd1, 6'd1),
      // Upper bits set, bit 0 clear: the backlight goes off.
      reg_row(ADDR_BACKLIGHT_ON, 32'hFFFF_FFFE),
      known_row(CMD_INSTR,  8'hFF, 2'd0, 6'd0,  4, 32'hF4F0F4F0),
      known_row(CMD_DATA,   8'h00, 2'd0, 6'd0,  4, 32'h05010501),
      known_row(CMD_NIBBLE, 8'hF0, 2'd0, 6'd0,  2, 32'hF4F00000),
      checked_row(CMD_CURSOR, 8'h00, 2'd1, 6'd0),
      reg_row(ADDR_DISPLAY_READY, 32'hFFFF_FFFE),
      known_row(CMD_DATA,   8'h41, 2'd0, 6'd0,  0, 32'h0),
      reg_row(ADDR_DISPLAY_READY, 32'h1),
      reg_row(ADDR_BACKLIGHT_ON, 32'h1),
      checked_row(CMD_INSTR,  8'h28, 2'd0, 6'd0)
    };

    // Hold reset once, then release it.
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed rows; register writes only with the block idle.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].is_write) begin
        settle();
        reg_write(directed_rows[i].addr, directed_rows[i].wdata);
      end else begin
        send_request(directed_rows[i].item, directed_rows[i].typed,
                     directed_rows[i].n, directed_rows[i].bytes);
        sender_gap();
      end
    end

    // Random phases over the register settings, mostly with the display ready.
    for (p = 0; p < PHASES; p++) begin
      rdy = (p == 2 || p == 6) ? 1'b0 : 1'b1;
      bl  = (p == 6) ? 1'b0 : ~p[0];
      settle();
      reg_write(ADDR_DISPLAY_READY, ($urandom() & ~32'h1) | {31'h0, rdy});
      reg_write(ADDR_BACKLIGHT_ON, ($urandom() & ~32'h1) | {31'h0, bl});
      count = rdy ? 46 : 12;
      // In one phase, hold off the receiver while offering back to back,
      // so the job queue fills and the input stalls.
      no_gaps = (p == 3);
      if (p == 3) hold_req = 1'b1;
      for (int k = 0; k < count; k++) begin
        it = random_request();
        send_request(it, 1'b0, 0, 32'h0);
        // Pause mid-phase until every pending byte has drained.
        if (p == 5 && k == 25) settle();
        else sender_gap();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_lcd_nibble_expander_sequencer: clean");
    end else begin
      $display("tb_lcd_nibble_expander_sequencer: errors");
    end
    $finish;
  end

endmodule
